@@ rtl/core/bqd_pkg.sv @@
// Shared constants and register indexes for the biquad filter core.
package bqd_pkg;

   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int COEF_FRAC_BITS_DEF = 16;
   localparam int COEF_INT_BITS      = 3;
   localparam int DELAY_WIDTH        = 40;
   localparam int CSR_IDX_WIDTH      = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COEF_B0      = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COEF_B1      = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COEF_B2      = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COEF_A1      = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COEF_A2      = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SECOND_ORDER = 3'd5;

endpackage

@@ rtl/core/bqd_if.sv @@
// Valid/ready stream interfaces for samples in and filtered samples out.
interface bqd_req_if #(
   parameter int SAMPLE_WIDTH = bqd_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqd_rsp_if #(
   parameter int SAMPLE_WIDTH = bqd_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           overflow;

   modport source (output valid, output sample_out, output overflow, input ready);
   modport sink   (input valid, input sample_out, input overflow, output ready);
endinterface

@@ rtl/core/bqd_csr.sv @@
// Coefficient and mode register bank with write decode.
module bqd_csr #(
   parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF,
   localparam int CW = COEF_FRAC_BITS + bqd_pkg::COEF_INT_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wen,
   input  logic [bqd_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [CW-1:0]                          csr_wdata,
   output logic signed [CW-1:0]                   coef_b0,
   output logic signed [CW-1:0]                   coef_b1,
   output logic signed [CW-1:0]                   coef_b2,
   output logic signed [CW-1:0]                   coef_a1,
   output logic signed [CW-1:0]                   coef_a2,
   output logic                                   second_order
);

   localparam logic signed [CW-1:0] B0_RESET = CW'(1) << COEF_FRAC_BITS;

   logic signed [CW-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic                 order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff    <= B0_RESET;
         b1_ff    <= '0;
         b2_ff    <= '0;
         a1_ff    <= '0;
         a2_ff    <= '0;
         order_ff <= 1'b1;
      end else if (csr_wen) begin
         // out-of-range indexes drop the write
         case (csr_index)
            bqd_pkg::CSR_COEF_B0:      b0_ff    <= csr_wdata;
            bqd_pkg::CSR_COEF_B1:      b1_ff    <= csr_wdata;
            bqd_pkg::CSR_COEF_B2:      b2_ff    <= csr_wdata;
            bqd_pkg::CSR_COEF_A1:      a1_ff    <= csr_wdata;
            bqd_pkg::CSR_COEF_A2:      a2_ff    <= csr_wdata;
            bqd_pkg::CSR_SECOND_ORDER: order_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign coef_b0      = b0_ff;
   assign coef_b1      = b1_ff;
   assign coef_b2      = b2_ff;
   assign coef_a1      = a1_ff;
   assign coef_a2      = a2_ff;
   assign second_order = order_ff;

endmodule

@@ rtl/core/biquad_df2t_filter_core.sv @@
// Top level: transposed direct form II biquad with one shared multiplier.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------
//  req_chan | in  | valid / ready        | sample_in (signed Q1.15)
//  rsp_chan | out | valid / ready        | sample_out (signed Q1.15), overflow
//  csr_*    | in  | csr_wen, no stall    | csr_index, csr_wdata
//
//  Second order runs 9 sequencer steps after the accept; first order skips the
//  second-delay step (8 steps). The five products share a single registered
//  multiplier, which sets the number of steps.
//  req_chan.ready is high only while the sequencer idles; the last step holds while
//  the previous result still waits in the output register for rsp_chan.ready.
//  Synchronous active-high reset restores b0 = 1.0, second order, zero delays.
module biquad_df2t_filter_core #(
   parameter int SAMPLE_WIDTH   = bqd_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF,
   localparam int CW = COEF_FRAC_BITS + bqd_pkg::COEF_INT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   bqd_req_if.sink                           req_chan,
   bqd_rsp_if.source                         rsp_chan,
   input  logic                              csr_wen,
   input  logic [bqd_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CW-1:0]                     csr_wdata
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int DW  = bqd_pkg::DELAY_WIDTH;
   localparam int PW  = SW + CW;
   localparam int AW  = ((PW > DW) ? PW : DW) + 3;

   localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [AW-1:0] Y_MAX = (AW'(1) << (SW - 1)) - AW'(1);
   localparam logic signed [AW-1:0] Y_MIN = -Y_MAX - AW'(1);
   localparam logic signed [AW-1:0] D_MAX = (AW'(1) << (DW - 1)) - AW'(1);
   localparam logic signed [AW-1:0] D_MIN = -D_MAX - AW'(1);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_B0    = 10'b00_0000_0010,
      ST_Y     = 10'b00_0000_0100,
      ST_CLAMP = 10'b00_0000_1000,
      ST_B1    = 10'b00_0001_0000,
      ST_A1    = 10'b00_0010_0000,
      ST_B2    = 10'b00_0100_0000,
      ST_A2    = 10'b00_1000_0000,
      ST_D2    = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } bqd_state_type;

   logic signed [CW-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
   logic                 second_order;

   bqd_csr #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .coef_b0      (coef_b0),
      .coef_b1      (coef_b1),
      .coef_b2      (coef_b2),
      .coef_a1      (coef_a1),
      .coef_a2      (coef_a2),
      .second_order (second_order)
   );

   bqd_state_type        state_ff, state_in;
   logic signed [SW-1:0] x_ff, x_in;
   logic signed [SW-1:0] y_ff, y_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [DW-1:0] delay_one_ff, delay_one_in;
   logic signed [DW-1:0] delay_two_ff, delay_two_in;
   logic                 sat_ff, sat_in;
   logic                 out_valid_ff, out_valid_in;
   logic signed [SW-1:0] out_sample_ff, out_sample_in;
   logic                 out_ovf_ff, out_ovf_in;

   logic signed [CW-1:0] mul_coef;
   logic signed [SW-1:0] mul_smp;
   logic signed [AW-1:0] y_shift;
   logic signed [AW-1:0] d2_sum;
   logic                 req_beat;
   logic                 out_free;

   assign req_beat = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign y_shift  = acc_ff >>> COEF_FRAC_BITS;
   assign d2_sum   = acc_ff - AW'(prod_ff);

   // shared multiplier operand select
   always_comb begin
      mul_coef = coef_b0;
      mul_smp  = x_ff;
      case (state_ff)
         ST_B0:   begin mul_coef = coef_b0; mul_smp = x_ff; end
         ST_B1:   begin mul_coef = coef_b1; mul_smp = x_ff; end
         ST_A1:   begin mul_coef = coef_a1; mul_smp = y_ff; end
         ST_B2:   begin mul_coef = coef_b2; mul_smp = x_ff; end
         ST_A2:   begin mul_coef = coef_a2; mul_smp = y_ff; end
         default: begin mul_coef = coef_b0; mul_smp = x_ff; end
      endcase
      prod_in = PW'(mul_coef) * PW'(mul_smp);
   end

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      acc_in        = acc_ff;
      delay_one_in  = delay_one_ff;
      delay_two_in  = delay_two_ff;
      sat_in        = sat_ff;
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_ovf_in    = out_ovf_ff;

      if (rsp_chan.valid && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               x_in     = req_chan.sample_in;
               sat_in   = 1'b0;
               state_in = ST_B0;
            end
         end
         ST_B0: state_in = ST_Y;
         ST_Y: begin
            acc_in   = AW'(prod_ff) + AW'(delay_one_ff) + ROUND_HALF;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (y_shift > Y_MAX) begin
               y_in   = SW'(Y_MAX);
               sat_in = 1'b1;
            end else if (y_shift < Y_MIN) begin
               y_in   = SW'(Y_MIN);
               sat_in = 1'b1;
            end else begin
               y_in = SW'(y_shift);
            end
            state_in = ST_B1;
         end
         ST_B1: state_in = ST_A1;
         ST_A1: begin
            // b1*x plus the old second delay (second order only)
            acc_in   = AW'(prod_ff) + (second_order ? AW'(delay_two_ff) : AW'(0));
            state_in = ST_B2;
         end
         ST_B2: begin
            acc_in   = acc_ff - AW'(prod_ff);
            state_in = ST_A2;
         end
         ST_A2: begin
            if (acc_ff > D_MAX) begin
               delay_one_in = DW'(D_MAX);
               sat_in       = 1'b1;
            end else if (acc_ff < D_MIN) begin
               delay_one_in = DW'(D_MIN);
               sat_in       = 1'b1;
            end else begin
               delay_one_in = DW'(acc_ff);
            end
            acc_in   = AW'(prod_ff);
            state_in = second_order ? ST_D2 : ST_DONE;
         end
         ST_D2: begin
            if (d2_sum > D_MAX) begin
               delay_two_in = DW'(D_MAX);
               sat_in       = 1'b1;
            end else if (d2_sum < D_MIN) begin
               delay_two_in = DW'(D_MIN);
               sat_in       = 1'b1;
            end else begin
               delay_two_in = DW'(d2_sum);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register frees up
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_sample_in = y_ff;
               out_ovf_in    = sat_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         delay_one_ff <= delay_one_in;
         delay_two_ff <= delay_two_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      sat_ff        <= sat_in;
      out_sample_ff <= out_sample_in;
      out_ovf_ff    <= out_ovf_in;
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.sample_out = out_sample_ff;
   assign rsp_chan.overflow   = out_ovf_ff;

endmodule
